// ===== rtl/assert_macros.svh =====
// Assertion macros for the line rasterizer RTL.
// Included by lpr_stepper, the module that carries concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);
`else
`define ASSERT_IMPLIES(lbl, clk, rst_n, pre, post, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)
`endif
`endif

// ===== rtl/lpr_pkg.sv =====
// Types, codes and helpers for the line pixel rasterizer.
// Used by lpr_stepper, lpr_addr and line_pixel_rasterizer_core; no dependencies.
`default_nettype none

package lpr_pkg;

    localparam int COORD_W        = 10;
    localparam int COLOR_W        = 4;
    localparam int ERR_W          = 11;
    localparam int OFFSET_W       = 16;
    localparam int MASK_W         = 8;
    localparam int IN_TDATA_W     = 48;
    localparam int OUT_TDATA_W    = 48;

    localparam int SCREEN_WIDTH_DEF  = 640;
    localparam int SCREEN_HEIGHT_DEF = 480;

    localparam logic [MASK_W-1:0] MASK_MSB = 8'h80;

    // operation codes carried in tuser
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

    typedef enum logic [1:0] {
        SGN_NONE  = 2'b00,
        SGN_PLUS  = 2'b01,
        SGN_MINUS = 2'b11
    } t_sign;

    typedef logic [COORD_W-1:0] t_coord;

    // load word, x_start in the low bits
    typedef struct packed {
        logic [COLOR_W-1:0] pen_color;
        t_coord             y_end;
        t_coord             x_end;
        t_coord             y_start;
        t_coord             x_start;
    } t_load;

    // pixel handed from the stepper to the address stage
    typedef struct packed {
        t_coord             x;
        t_coord             y;
        logic [COLOR_W-1:0] color;
        logic               last;
    } t_pixel;

    function automatic t_coord move_axis(input t_coord v, input t_sign s);
        t_coord r;
        case (s)
            SGN_PLUS:  r = v + t_coord'(1);
            SGN_MINUS: r = v - t_coord'(1);
            default:   r = v;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/line_pixel_rasterizer_core.sv =====
// Channel   Dir  tdata (low bit up)                                  tuser        tlast
// s_axis    in   x_start y_start x_end y_end pen_color               operation    -
// m_axis    out  pixel_x pixel_y byte_offset bit_mask pixel_color      off_screen   last_pixel
//
// One word per clock in both directions while m_axis does not stall; a step word's pixel
// passes the pixel register, then the address/output register, before it is valid on m_axis.
// Load words and steps with no active line produce no output word.
// Reset (i_rst_n low, synchronous) clears the line state: no line is active.
// A stalled output holds its word; the pixel register behind it keeps taking
// input words until a step fills it, then s_axis_tready drops.
// Depends on lpr_pkg, lpr_stepper and lpr_addr.
`default_nettype none

module line_pixel_rasterizer_core #(
    parameter int SCREEN_WIDTH  = lpr_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = lpr_pkg::SCREEN_HEIGHT_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // x_start[9:0], y_start[19:10], x_end[29:20], y_end[39:30],
    // pen_color[43:40], zero[47:44]
    input  wire logic [lpr_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // operation[0]
    input  wire logic [0:0]                          s_axis_tuser,
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // pixel_x[9:0], pixel_y[19:10], byte_offset[35:20], bit_mask[43:36],
    // pixel_color[47:44]
    output logic [lpr_pkg::OUT_TDATA_W-1:0]          m_axis_tdata,
    // off_screen[0]
    output logic [0:0]                               m_axis_tuser,
    output logic                                     m_axis_tlast
);
    import lpr_pkg::*;

    t_load               w_load;
    logic                w_pix_valid;
    t_pixel              w_pix;
    logic                w_addr_ready;
    logic [COORD_W-1:0]  w_x, w_y;
    logic [OFFSET_W-1:0] w_offset;
    logic [MASK_W-1:0]   w_mask;
    logic [COLOR_W-1:0]  w_color;
    logic                w_off;

    assign w_load = s_axis_tdata[$bits(t_load)-1:0];

    lpr_stepper u_stepper (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_op         (s_axis_tuser[0]),
        .i_load       (w_load),
        .i_down_ready (w_addr_ready),
        .o_pix_valid  (w_pix_valid),
        .o_pix        (w_pix)
    );

    lpr_addr #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_addr (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_pix_valid),
        .i_pix    (w_pix),
        .o_ready  (w_addr_ready),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_x      (w_x),
        .o_y      (w_y),
        .o_offset (w_offset),
        .o_mask   (w_mask),
        .o_color  (w_color),
        .o_off    (w_off),
        .o_last   (m_axis_tlast)
    );

    assign m_axis_tdata = {w_color, w_mask, w_offset, w_y, w_x};
    assign m_axis_tuser = w_off;

endmodule

`default_nettype wire

// ===== rtl/lpr_stepper.sv =====
// Bresenham stepper: line setup on load, one pixel per step, pixel register.
// Depends on lpr_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module lpr_stepper (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire logic           i_op,
    input  wire lpr_pkg::t_load i_load,
    input  wire logic           i_down_ready,
    output logic                o_pix_valid,
    output lpr_pkg::t_pixel     o_pix
);
    import lpr_pkg::*;

    t_coord             r_x, r_y, r_dx, r_dy, r_left;
    t_sign              r_sx, r_sy;
    logic [ERR_W-1:0]   r_err;
    logic               r_x_major;
    logic [COLOR_W-1:0] r_color;
    logic               r_pix_valid;
    t_pixel             r_pix;

    t_coord             n_x, n_y, n_dx, n_dy, n_left;
    t_sign              n_sx, n_sy;
    logic [ERR_W-1:0]   n_err;
    logic               n_x_major;
    logic [COLOR_W-1:0] n_color;
    logic               n_pix_valid;
    t_pixel             n_pix;

    logic               w_accept;
    logic               w_step;
    t_coord             w_maj, w_min;
    logic [ERR_W-1:0]   w_err_sum;
    logic               w_minor_mv;
    t_coord             w_ldx, w_ldy;

    assign o_ready  = !r_pix_valid || i_down_ready;
    assign w_accept = i_valid && o_ready;
    assign w_step   = w_accept && (i_op == OP_STEP) && (r_left != '0);

    assign w_maj      = r_x_major ? r_dx : r_dy;
    assign w_min      = r_x_major ? r_dy : r_dx;
    assign w_err_sum  = r_err + {1'b0, w_min};
    assign w_minor_mv = (w_err_sum >= {1'b0, w_maj});

    assign w_ldx = (i_load.x_end >= i_load.x_start) ? (i_load.x_end - i_load.x_start)
                                                    : (i_load.x_start - i_load.x_end);
    assign w_ldy = (i_load.y_end >= i_load.y_start) ? (i_load.y_end - i_load.y_start)
                                                    : (i_load.y_start - i_load.y_end);

    always_comb begin
        n_x         = r_x;
        n_y         = r_y;
        n_dx        = r_dx;
        n_dy        = r_dy;
        n_left      = r_left;
        n_sx        = r_sx;
        n_sy        = r_sy;
        n_err       = r_err;
        n_x_major   = r_x_major;
        n_color     = r_color;
        n_pix_valid = r_pix_valid && !i_down_ready;
        n_pix       = r_pix;

        if (w_accept && (i_op == OP_LOAD)) begin
            n_x     = i_load.x_start;
            n_y     = i_load.y_start;
            n_color = i_load.pen_color;
            n_dx    = w_ldx;
            n_dy    = w_ldy;
            if (i_load.x_end > i_load.x_start) begin
                n_sx = SGN_PLUS;
            end else if (i_load.x_end == i_load.x_start) begin
                n_sx = SGN_NONE;
            end else begin
                n_sx = SGN_MINUS;
            end
            if (i_load.y_end > i_load.y_start) begin
                n_sy = SGN_PLUS;
            end else if (i_load.y_end == i_load.y_start) begin
                n_sy = SGN_NONE;
            end else begin
                n_sy = SGN_MINUS;
            end
            n_x_major = (w_ldx >= w_ldy);
            n_left    = n_x_major ? w_ldx : w_ldy;
            n_err     = {2'b00, n_left[COORD_W-1:1]};
        end else if (w_step) begin
            n_err = w_minor_mv ? (w_err_sum - {1'b0, w_maj}) : w_err_sum;
            n_x   = (r_x_major || w_minor_mv) ? move_axis(r_x, r_sx) : r_x;
            n_y   = (!r_x_major || w_minor_mv) ? move_axis(r_y, r_sy) : r_y;
            n_left = r_left - t_coord'(1);
        end

        if (w_accept) begin
            n_pix_valid = w_step;
            n_pix.x     = n_x;
            n_pix.y     = n_y;
            n_pix.color = r_color;
            n_pix.last  = (r_left == t_coord'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x         <= '0;
            r_y         <= '0;
            r_dx        <= '0;
            r_dy        <= '0;
            r_left      <= '0;
            r_sx        <= SGN_NONE;
            r_sy        <= SGN_NONE;
            r_err       <= '0;
            r_x_major   <= 1'b0;
            r_color     <= '0;
            r_pix_valid <= 1'b0;
        end else begin
            r_x         <= n_x;
            r_y         <= n_y;
            r_dx        <= n_dx;
            r_dy        <= n_dy;
            r_left      <= n_left;
            r_sx        <= n_sx;
            r_sy        <= n_sy;
            r_err       <= n_err;
            r_x_major   <= n_x_major;
            r_color     <= n_color;
            r_pix_valid <= n_pix_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pix <= n_pix;
    end

    assign o_pix_valid = r_pix_valid;
    assign o_pix       = r_pix;

    `ASSERT_NEXT(a_idle_step_silent, i_clk, i_rst_n, w_accept && (i_op == OP_STEP) && (r_left == '0), !r_pix_valid, "step without active line produced a pixel")
    `ASSERT_NEXT(a_step_counts_down, i_clk, i_rst_n, w_step, r_pix_valid && (r_left == ($past(r_left) - t_coord'(1))), "step did not emit a pixel and count down")
    `ASSERT_IMPLIES(a_err_bounded, i_clk, i_rst_n, r_left != '0, (r_err < {1'b0, (r_x_major ? r_dx : r_dy)}), "error term reached major delta")

endmodule

`default_nettype wire

// ===== rtl/lpr_addr.sv =====
// Address stage: screen clip, planar byte offset, bit mask and output register.
// Depends on lpr_pkg.
`default_nettype none

module lpr_addr #(
    parameter int SCREEN_WIDTH  = lpr_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = lpr_pkg::SCREEN_HEIGHT_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    input  wire lpr_pkg::t_pixel                 i_pix,
    output logic                                 o_ready,
    output logic                                 o_valid,
    input  wire logic                            i_ready,
    output logic [lpr_pkg::COORD_W-1:0]          o_x,
    output logic [lpr_pkg::COORD_W-1:0]          o_y,
    output logic [lpr_pkg::OFFSET_W-1:0]         o_offset,
    output logic [lpr_pkg::MASK_W-1:0]           o_mask,
    output logic [lpr_pkg::COLOR_W-1:0]         o_color,
    output logic                                 o_off,
    output logic                                 o_last
);
    import lpr_pkg::*;

    localparam int DIM_W  = COORD_W + 1;
    localparam int PROD_W = COORD_W + DIM_W;
    localparam logic [DIM_W-1:0] WIDTH_C  = DIM_W'(SCREEN_WIDTH);
    localparam logic [DIM_W-1:0] HEIGHT_C = DIM_W'(SCREEN_HEIGHT);

    logic                r_valid;
    logic [COORD_W-1:0]  r_x, r_y;
    logic [OFFSET_W-1:0] r_offset;
    logic [MASK_W-1:0]   r_mask;
    logic [COLOR_W-1:0]  r_color;
    logic                r_off, r_last;

    logic                n_valid;
    logic                w_off;
    logic [PROD_W-1:0]   w_lin;
    logic [OFFSET_W-1:0] w_offset;

    assign o_ready = !r_valid || i_ready;
    assign n_valid = o_ready ? i_valid : r_valid;

    assign w_off    = ({1'b0, i_pix.x} >= WIDTH_C) || ({1'b0, i_pix.y} >= HEIGHT_C);
    // row-major pixel index; eight pixels per planar byte
    assign w_lin    = ({{DIM_W{1'b0}}, i_pix.y} * {{COORD_W{1'b0}}, WIDTH_C})
                    + {{DIM_W{1'b0}}, i_pix.x};
    assign w_offset = w_off ? '0 : w_lin[OFFSET_W+2:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_x      <= i_pix.x;
            r_y      <= i_pix.y;
            r_offset <= w_offset;
            r_mask   <= MASK_MSB >> i_pix.x[2:0];
            r_color  <= i_pix.color;
            r_off    <= w_off;
            r_last   <= i_pix.last;
        end
    end

    assign o_valid  = r_valid;
    assign o_x      = r_x;
    assign o_y      = r_y;
    assign o_offset = r_offset;
    assign o_mask   = r_mask;
    assign o_color  = r_color;
    assign o_off    = r_off;
    assign o_last   = r_last;

endmodule

`default_nettype wire

// ===== test/line_pixel_rasterizer_core_tb.sv =====
// Self-checking testbench for line_pixel_rasterizer_core: a directed table of lines, then random
// line bursts under four idle/stall mixes; words checked against the table or a local Bresenham model.
// Depends on lpr_pkg and the core RTL.
module line_pixel_rasterizer_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lpr_pkg::*;

    localparam int SCR_W     = SCREEN_WIDTH_DEF;
    localparam int SCR_H     = SCREEN_HEIGHT_DEF;
    localparam int HANG_MAX  = 1000;
    localparam int PHASE_LEN = 480;

    typedef struct packed {
        t_coord             x;
        t_coord             y;
        logic [OFFSET_W-1:0] offset;
        logic [MASK_W-1:0]  mask;
        logic [COLOR_W-1:0] color;
        logic               off;
        logic               last;
    } t_drawn_pixel;

    localparam t_drawn_pixel NO_PIXEL = '0;

    typedef struct {
        logic         op;
        int           xs, ys, xe, ye, col;
        bit           fixed;
        bit           has_px;
        t_drawn_pixel px;
    } t_dir_row;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic [0:0]             s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [0:0]             m_axis_tuser;
    logic                   m_axis_tlast;

    line_pixel_rasterizer_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #2 i_clk = ~i_clk;

    // line state of the model
    t_coord     pos_x, pos_y;
    t_coord     run_x, run_y;
    t_sign      dir_x, dir_y;
    logic [ERR_W-1:0] err_acc;
    t_coord     remaining;
    logic       along_x;
    logic [COLOR_W-1:0] pen;

    t_drawn_pixel pending_pixels[$];
    int           mismatches;
    int           hang_cycles;
    int           src_idle;
    int           sink_stall;

    // expectation typed into the table for the word on the bus
    bit           row_fixed;
    bit           row_has_pixel;
    t_drawn_pixel row_pixel;

    t_dir_row plan [25] = '{
        // step straight after reset: nothing active
        '{OP_STEP, 1023, 1023, 1023, 1023, 15, 1'b1, 1'b0, NO_PIXEL},
        // zero-length line, then a step that must stay silent
        '{OP_LOAD, 0, 0, 0, 0, 0, 1'b1, 1'b0, NO_PIXEL},
        '{OP_STEP, 0, 0, 0, 0, 0, 1'b1, 1'b0, NO_PIXEL},
        // short horizontal line, start point skipped, end point drawn
        '{OP_LOAD, 0, 0, 3, 0, 15, 1'b1, 1'b0, NO_PIXEL},
        '{OP_STEP, 0, 0, 0, 0, 0, 1'b1, 1'b1, '{10'd1, 10'd0, 16'd0, 8'h40, 4'hF, 1'b0, 1'b0}},
        '{OP_STEP, 0, 0, 0, 0, 0, 1'b1, 1'b1, '{10'd2, 10'd0, 16'd0, 8'h20, 4'hF, 1'b0, 1'b0}},
        '{OP_STEP, 0, 0, 0, 0, 0, 1'b1, 1'b1, '{10'd3, 10'd0, 16'd0, 8'h10, 4'hF, 1'b0, 1'b1}},
        '{OP_STEP, 1023, 1023, 1023, 1023, 15, 1'b1, 1'b0, NO_PIXEL},
        // vertical line going up at the far corner, all off screen
        '{OP_LOAD, 1023, 1023, 1023, 1020, 10, 1'b1, 1'b0, NO_PIXEL},
        '{OP_STEP, 0, 0, 0, 0, 0, 1'b1, 1'b1,
          '{10'd1023, 10'd1022, 16'd0, 8'h01, 4'hA, 1'b1, 1'b0}},
        '{OP_STEP, 0, 0, 0, 0, 0, 1'b0, 1'b0, NO_PIXEL},
        '{OP_STEP, 0, 0, 0, 0, 0, 1'b1, 1'b1,
          '{10'd1023, 10'd1020, 16'd0, 8'h01, 4'hA, 1'b1, 1'b1}},
        // full diagonal, cut short by the next load
        '{OP_LOAD, 0, 0, 1023, 1023, 5, 1'b1, 1'b0, NO_PIXEL},
        '{OP_STEP, 0, 0, 0, 0, 0, 1'b0, 1'b0, NO_PIXEL},
        '{OP_STEP, 0, 0, 0, 0, 0, 1'b0, 1'b0, NO_PIXEL},
        // one step across the bottom right screen corner
        '{OP_LOAD, 639, 479, 640, 480, 3, 1'b1, 1'b0, NO_PIXEL},
        '{OP_STEP, 0, 0, 0, 0, 0, 1'b1, 1'b1,
          '{10'd640, 10'd480, 16'd0, 8'h80, 4'h3, 1'b1, 1'b1}},
        // last on-screen byte
        '{OP_LOAD, 639, 479, 638, 479, 9, 1'b1, 1'b0, NO_PIXEL},
        '{OP_STEP, 0, 0, 0, 0, 0, 1'b1, 1'b1,
          '{10'd638, 10'd479, 16'd38399, 8'h02, 4'h9, 1'b0, 1'b1}},
        // steep line, y major
        '{OP_LOAD, 5, 5, 7, 1000, 7, 1'b1, 1'b0, NO_PIXEL},
        '{OP_STEP, 0, 0, 0, 0, 0, 1'b0, 1'b0, NO_PIXEL},
        '{OP_STEP, 0, 0, 0, 0, 0, 1'b0, 1'b0, NO_PIXEL},
        // x going negative, y going positive
        '{OP_LOAD, 1023, 0, 0, 1023, 12, 1'b1, 1'b0, NO_PIXEL},
        '{OP_STEP, 0, 0, 0, 0, 0, 1'b0, 1'b0, NO_PIXEL},
        '{OP_STEP, 0, 0, 0, 0, 0, 1'b0, 1'b0, NO_PIXEL}
    };

    function automatic t_coord nudge(input t_coord v, input t_sign d);
        if (d == SGN_PLUS)  return v + 10'd1;
        if (d == SGN_MINUS) return v - 10'd1;
        return v;
    endfunction

    // Bresenham model: a load latches the line, a step yields the next pixel
    function automatic void rasterize(input logic op, input t_load ld,
                                      output bit emits, output t_drawn_pixel px);
        int unsigned lin;
        emits = 1'b0;
        px    = NO_PIXEL;
        if (op == OP_LOAD) begin
            pos_x = ld.x_start;
            pos_y = ld.y_start;
            pen   = ld.pen_color;
            if (ld.x_end >= ld.x_start) begin
                run_x = ld.x_end - ld.x_start;
                dir_x = (ld.x_end > ld.x_start) ? SGN_PLUS : SGN_NONE;
            end else begin
                run_x = ld.x_start - ld.x_end;
                dir_x = SGN_MINUS;
            end
            if (ld.y_end >= ld.y_start) begin
                run_y = ld.y_end - ld.y_start;
                dir_y = (ld.y_end > ld.y_start) ? SGN_PLUS : SGN_NONE;
            end else begin
                run_y = ld.y_start - ld.y_end;
                dir_y = SGN_MINUS;
            end
            along_x   = (run_x >= run_y);
            remaining = along_x ? run_x : run_y;
            err_acc   = {1'b0, remaining} >> 1;
        end else if (remaining != 0) begin
            if (along_x) begin
                err_acc = err_acc + run_y;
                if (err_acc >= run_x) begin
                    err_acc = err_acc - run_x;
                    pos_y   = nudge(pos_y, dir_y);
                end
                pos_x = nudge(pos_x, dir_x);
            end else begin
                err_acc = err_acc + run_x;
                if (err_acc >= run_y) begin
                    err_acc = err_acc - run_y;
                    pos_x   = nudge(pos_x, dir_x);
                end
                pos_y = nudge(pos_y, dir_y);
            end
            remaining = remaining - 10'd1;
            px.x      = pos_x;
            px.y      = pos_y;
            px.off    = (pos_x >= SCR_W) || (pos_y >= SCR_H);
            lin       = pos_y * SCR_W + pos_x;
            px.offset = px.off ? '0 : OFFSET_W'(lin >> 3);
            px.mask   = 8'h80 >> pos_x[2:0];
            px.color  = pen;
            px.last   = (remaining == 0);
            emits     = 1'b1;
        end
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin : scoreboard
        bit           emits;
        t_drawn_pixel px;
        t_drawn_pixel want;
        t_drawn_pixel got;
        bit           moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                moved = 1'b1;
                rasterize(s_axis_tuser[0], s_axis_tdata[43:0], emits, px);
                if (row_fixed) begin
                    if (row_has_pixel)
                        pending_pixels.push_back(row_pixel);
                end else if (emits) begin
                    pending_pixels.push_back(px);
                end
            end
            if (m_axis_tvalid && m_axis_tready) begin
                moved      = 1'b1;
                got.x      = m_axis_tdata[9:0];
                got.y      = m_axis_tdata[19:10];
                got.offset = m_axis_tdata[35:20];
                got.mask   = m_axis_tdata[43:36];
                got.color  = m_axis_tdata[47:44];
                got.off    = m_axis_tuser[0];
                got.last   = m_axis_tlast;
                if (pending_pixels.size() == 0) begin
                    $display("%0t: unexpected pixel word, expected none, got 0x%0h",
                             $time, got);
                    mismatches++;
                end else begin
                    want = pending_pixels.pop_front();
                    check_field("pixel_x", want.x, got.x);
                    check_field("pixel_y", want.y, got.y);
                    check_field("byte_offset", want.offset, got.offset);
                    check_field("bit_mask", want.mask, got.mask);
                    check_field("pixel_color", want.color, got.color);
                    check_field("off_screen", want.off, got.off);
                    check_field("last_pixel", want.last, got.last);
                end
            end
        end
        hang_cycles = moved ? 0 : hang_cycles + 1;
        if (hang_cycles >= HANG_MAX) begin
            $display("%0t: no word moved for %0d cycles", $time, HANG_MAX);
            $display("Some tests failed");
            $finish;
        end
    end

    always @(negedge i_clk)
        m_axis_tready = ($urandom_range(99) >= sink_stall);

    function automatic t_load rand_load();
        t_load ld;
        ld.x_start   = $urandom_range(1023);
        ld.y_start   = $urandom_range(1023);
        ld.x_end     = $urandom_range(1023);
        ld.y_end     = $urandom_range(1023);
        ld.pen_color = $urandom_range(15);
        return ld;
    endfunction

    function automatic t_coord near(input int v, input int spread);
        int e;
        e = v + int'($urandom_range(2 * spread)) - spread;
        if (e < 0)    e = 0;
        if (e > 1023) e = 1023;
        return t_coord'(e);
    endfunction

    task automatic send_word(input logic op, input t_load ld, input bit fixed,
                             input bit has_px, input t_drawn_pixel px);
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = op;
        s_axis_tdata  = {4'b0, ld};
        row_fixed     = fixed;
        row_has_pixel = has_px;
        row_pixel     = px;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // bursts of a load followed by steps, some past the end, some cut short; also lone steps and zero-length loads
    task automatic draw_random_lines(input int quota);
        int    sent;
        int    steps;
        int    reach;
        int    dx, dy;
        int    k;
        t_load ld;
        sent = 0;
        while (sent < quota) begin
            k  = $urandom_range(99);
            ld = rand_load();
            if (k < 4) begin
                send_word(OP_STEP, ld, 1'b0, 1'b0, NO_PIXEL);
                sent++;
            end else if (k < 8) begin
                ld.x_end = ld.x_start;
                ld.y_end = ld.y_start;
                send_word(OP_LOAD, ld, 1'b0, 1'b0, NO_PIXEL);
                sent++;
            end else begin
                if (k >= 14) begin
                    // keep some lines around the visible edge
                    if ($urandom_range(3) == 0) begin
                        ld.x_start = near(SCR_W, 12);
                        ld.y_start = near(SCR_H, 12);
                    end
                    ld.x_end = near(ld.x_start, 24);
                    ld.y_end = near(ld.y_start, 24);
                end
                dx    = int'(ld.x_end) - int'(ld.x_start);
                dy    = int'(ld.y_end) - int'(ld.y_start);
                reach = (dx < 0) ? -dx : dx;
                if (dy > reach || -dy > reach)
                    reach = (dy < 0) ? -dy : dy;
                if (k < 14)
                    steps = $urandom_range(1, 120);
                else if (k < 24)
                    steps = $urandom_range(reach);
                else
                    steps = reach + $urandom_range(2);
                send_word(OP_LOAD, ld, 1'b0, 1'b0, NO_PIXEL);
                repeat (steps)
                    send_word(OP_STEP, rand_load(), 1'b0, 1'b0, NO_PIXEL);
                sent += 1 + steps;
            end
        end
    endtask

    initial begin
        t_load ld;
        int    idle_src [4];
        int    idle_sink[4];
        idle_src  = '{0, 62, 0, 29};
        idle_sink = '{0, 0, 62, 29};
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        m_axis_tready = 1'b0;
        src_idle      = 0;
        sink_stall    = 0;
        mismatches    = 0;
        hang_cycles   = 0;
        row_fixed     = 1'b0;
        row_has_pixel = 1'b0;
        row_pixel     = NO_PIXEL;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (plan[i]) begin
            ld.x_start   = t_coord'(plan[i].xs);
            ld.y_start   = t_coord'(plan[i].ys);
            ld.x_end     = t_coord'(plan[i].xe);
            ld.y_end     = t_coord'(plan[i].ye);
            ld.pen_color = COLOR_W'(plan[i].col);
            send_word(plan[i].op, ld, plan[i].fixed, plan[i].has_px, plan[i].px);
        end

        for (int ph = 0; ph < 4; ph++) begin
            src_idle   = idle_src[ph];
            sink_stall = idle_sink[ph];
            draw_random_lines(PHASE_LEN);
        end

        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/lpr_pkg.sv
rtl/lpr_stepper.sv
rtl/lpr_addr.sv
rtl/line_pixel_rasterizer_core.sv
test/line_pixel_rasterizer_core_tb.sv
